/* rtl/arm_pkg.sv */
// Shared types and constants for the axis rotation matrix generator.
// No dependencies; every other file in rtl/ imports this package.
package arm_pkg;

  localparam int AngW  = 24;             // angle, 1/128 degree units
  localparam int OpW   = 2;
  localparam int MatW  = 16;             // matrix entry, Q1.14
  localparam int OutFrac = MatW - 2;
  localparam int QW    = 64;             // series word, Q2.62
  localparam int FracW = 62;
  localparam int Terms = 10;             // correction terms per series
  localparam int DivW  = 9;              // largest divisor is 20*21
  localparam int RemW  = 10;             // remainder before correction < 2*divisor

  // one turn is 46080 units = 45 << 10
  localparam int TurnLoW      = 10;
  localparam int TurnOdd      = 45;
  localparam int TurnUnits    = TurnOdd << TurnLoW;
  localparam int HalfUnits    = TurnUnits / 2;
  localparam int QuarterUnits = TurnUnits / 4;
  localparam int EighthUnits  = TurnUnits / 8;
  localparam int AW = 16;                // reduced angle, 0..46079
  localparam int RW = 14;                // angle within a quadrant
  localparam int TW = 13;                // folded angle, 0..5760

  localparam logic [QW-1:0] PiQ62  = 64'hC90FDAA22168C234;
  localparam logic [QW-1:0] OneQ62 = 64'h4000_0000_0000_0000;
  localparam logic [QW:0]   RecipNum = {1'b1, {QW{1'b0}}};
  localparam logic signed [MatW-1:0] OneQ14 = 16'sd16384;

  localparam logic [OpW-1:0] OpAxisX = 2'd0;
  localparam logic [OpW-1:0] OpAxisY = 2'd1;
  localparam logic [OpW-1:0] OpAxisZ = 2'd2;

  typedef struct packed {
    logic signed [AngW-1:0] angle_deg;
    logic [OpW-1:0]         opcode;
  } arm_in_t;

  typedef struct packed {
    logic signed [MatW-1:0] m00;
    logic signed [MatW-1:0] m01;
    logic signed [MatW-1:0] m02;
    logic signed [MatW-1:0] m10;
    logic signed [MatW-1:0] m11;
    logic signed [MatW-1:0] m12;
    logic signed [MatW-1:0] m20;
    logic signed [MatW-1:0] m21;
    logic signed [MatW-1:0] m22;
  } arm_out_t;

  typedef struct packed {
    logic [1:0]     quad;
    logic           swap;               // sine and cosine exchanged by octant fold
    logic [OpW-1:0] opcode;
  } arm_meta_t;

  // one word of the series pipeline
  typedef struct packed {
    logic          valid;
    arm_meta_t     meta;
    logic [QW-1:0] x2;
    logic [QW-1:0] sterm;               // pending terms, not yet in the sums
    logic [QW-1:0] cterm;
    logic [QW-1:0] ssum;
    logic [QW-1:0] csum;
  } arm_ser_t;

endpackage

/* rtl/arm_mul.sv */
// 64x64 unsigned multiplier, three register stages, built from 32x32 partials.
// Depends on arm_pkg.
module arm_mul
  import arm_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [QW-1:0]   a,
  input  logic [QW-1:0]   b,
  output logic [2*QW-1:0] p
);

  localparam int HW = QW / 2;

  logic [QW-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [QW-1:0]   ll2_r, hh2_r;
  logic [QW:0]     mid_r;
  logic [2*QW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= QW'(a[HW-1:0]) * QW'(b[HW-1:0]);
      lh_r  <= QW'(a[HW-1:0]) * QW'(b[QW-1:HW]);
      hl_r  <= QW'(a[QW-1:HW]) * QW'(b[HW-1:0]);
      hh_r  <= QW'(a[QW-1:HW]) * QW'(b[QW-1:HW]);
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      ll2_r <= ll_r;
      hh2_r <= hh_r;
      p_r   <= {hh2_r, ll2_r} + {{(QW-HW-1){1'b0}}, mid_r, {HW{1'b0}}};
    end
  end

  assign p = p_r;

endmodule

/* rtl/arm_front.sv */
// Angle reduction, quadrant and octant fold, radian conversion and x^2.
// Depends on arm_pkg and arm_mul.
module arm_front
  import arm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  arm_in_t  in_data,
  output arm_ser_t ser_o
);

  localparam int UW = AngW + 1;
  localparam int HiW = UW - TurnLoW;
  localparam int RecipSh = 20;
  localparam int ResW = 6;
  localparam int AngOffset = ((1 << (AngW - 1)) / TurnUnits + 1) * TurnUnits;
  localparam logic [HiW-1:0] Recip45 = HiW'(((1 << RecipSh) + TurnOdd - 1) / TurnOdd);
  localparam logic [QW-1:0] Step = PiQ62 / QW'(HalfUnits);

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic signed [AngW-1:0] s1_ang_r;
  logic [OpW-1:0]       s1_op_r, s2_op_r, s3_op_r, s4_op_r, s5_op_r;
  logic [UW-1:0]        s2_u_r;
  logic [HiW-1:0]       s3_hi_r;
  logic [TurnLoW-1:0]   s3_lo_r;
  logic [DivW:0]        s3_q_r;
  logic [AW-1:0]        s4_a_r;
  logic [1:0]           s5_quad_r;
  logic [RW-1:0]        s5_rem_r;
  arm_meta_t            s6_meta_r;
  logic [TW-1:0]        s6_t_r;
  arm_ser_t             s7_r;
  arm_ser_t             dly_r [3];

  logic [2*HiW-1:0]     qprod;
  logic [HiW-1:0]       r45;
  logic [1:0]           quad_nxt;
  logic [RW-1:0]        rem_nxt;
  logic                 fold;
  arm_ser_t             s7_nxt;
  logic [2*QW-1:0]      x2_prod;

  assign qprod = (2*HiW)'(s2_u_r[UW-1:TurnLoW]) * (2*HiW)'(Recip45);
  assign r45   = s3_hi_r - HiW'(HiW'(s3_q_r) * HiW'(TurnOdd));

  always_comb begin
    if (s4_a_r >= AW'(3 * QuarterUnits)) begin
      quad_nxt = 2'd3;
      rem_nxt  = RW'(s4_a_r - AW'(3 * QuarterUnits));
    end else if (s4_a_r >= AW'(2 * QuarterUnits)) begin
      quad_nxt = 2'd2;
      rem_nxt  = RW'(s4_a_r - AW'(2 * QuarterUnits));
    end else if (s4_a_r >= AW'(QuarterUnits)) begin
      quad_nxt = 2'd1;
      rem_nxt  = RW'(s4_a_r - AW'(QuarterUnits));
    end else begin
      quad_nxt = 2'd0;
      rem_nxt  = RW'(s4_a_r);
    end
  end

  assign fold = s5_rem_r > RW'(EighthUnits);

  always_comb begin
    s7_nxt       = '0;
    s7_nxt.valid = s6_v_r;
    s7_nxt.meta  = s6_meta_r;
    s7_nxt.sterm = QW'(s6_t_r) * Step;
    s7_nxt.cterm = OneQ62;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_r.valid <= 1'b0;
      for (int i = 0; i < 3; i++) dly_r[i].valid <= 1'b0;
    end else if (en) begin
      s1_v_r   <= in_valid;
      s1_ang_r <= in_data.angle_deg;
      s1_op_r  <= in_data.opcode;
      // bias by a whole number of turns so the value is never negative
      s2_v_r   <= s1_v_r;
      s2_u_r   <= {s1_ang_r[AngW-1], s1_ang_r} + UW'(AngOffset);
      s2_op_r  <= s1_op_r;
      s3_v_r   <= s2_v_r;
      s3_hi_r  <= s2_u_r[UW-1:TurnLoW];
      s3_lo_r  <= s2_u_r[TurnLoW-1:0];
      s3_q_r   <= qprod[2*HiW-1:RecipSh];
      s3_op_r  <= s2_op_r;
      s4_v_r   <= s3_v_r;
      s4_a_r   <= {r45[ResW-1:0], s3_lo_r};
      s4_op_r  <= s3_op_r;
      s5_v_r    <= s4_v_r;
      s5_quad_r <= quad_nxt;
      s5_rem_r  <= rem_nxt;
      s5_op_r   <= s4_op_r;
      s6_v_r           <= s5_v_r;
      s6_meta_r.quad   <= s5_quad_r;
      s6_meta_r.opcode <= s5_op_r;
      s6_meta_r.swap   <= fold;
      s6_t_r <= fold ? TW'(RW'(QuarterUnits) - s5_rem_r) : TW'(s5_rem_r);
      s7_r     <= s7_nxt;
      dly_r[0] <= s7_r;
      dly_r[1] <= dly_r[0];
      dly_r[2] <= dly_r[1];
    end
  end

  arm_mul u_x2 (
    .clk (clk),
    .en  (en),
    .a   (s7_r.sterm),
    .b   (s7_r.sterm),
    .p   (x2_prod)
  );

  always_comb begin
    ser_o    = dly_r[2];
    ser_o.x2 = x2_prod[FracW+QW-1:FracW];
  end

endmodule

/* rtl/arm_term.sv */
// One Taylor step for sine and cosine together: term * x^2 >> 62, then an exact
// divide by a constant via reciprocal multiply and a one-step correction. Needs arm_pkg, arm_mul.
module arm_term
  import arm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [DivW-1:0] sdiv,
  input  logic [DivW-1:0] cdiv,
  input  logic [QW-1:0]   srecip,
  input  logic [QW-1:0]   crecip,
  input  logic            neg,
  input  arm_ser_t        ser_i,
  output arm_ser_t        ser_o
);

  localparam int SbDepth = 6;

  arm_ser_t        sb_r [SbDepth];
  logic [RemW-1:0] snl_r [3];
  logic [RemW-1:0] cnl_r [3];
  arm_ser_t        out_r;

  arm_ser_t        sb0_nxt;
  arm_ser_t        out_nxt;
  logic [2*QW-1:0] sp, cp, srp, crp;
  logic [QW-1:0]   sn, cn, sq0, cq0;
  logic [RemW-1:0] sprod, cprod, srem, crem;
  logic            sfix, cfix;

  // fold the pending term into the sums while it enters the multiplier
  always_comb begin
    sb0_nxt      = ser_i;
    sb0_nxt.ssum = neg ? ser_i.ssum - ser_i.sterm : ser_i.ssum + ser_i.sterm;
    sb0_nxt.csum = neg ? ser_i.csum - ser_i.cterm : ser_i.csum + ser_i.cterm;
  end

  arm_mul u_smul (.clk(clk), .en(en), .a(ser_i.sterm), .b(ser_i.x2), .p(sp));
  arm_mul u_cmul (.clk(clk), .en(en), .a(ser_i.cterm), .b(ser_i.x2), .p(cp));

  assign sn = sp[FracW+QW-1:FracW];
  assign cn = cp[FracW+QW-1:FracW];

  arm_mul u_sdiv (.clk(clk), .en(en), .a(sn), .b(srecip), .p(srp));
  arm_mul u_cdiv (.clk(clk), .en(en), .a(cn), .b(crecip), .p(crp));

  // estimate is the quotient or one below; the remainder fits in RemW bits
  assign sq0   = srp[2*QW-1:QW];
  assign cq0   = crp[2*QW-1:QW];
  assign sprod = RemW'(sq0[RemW-1:0] * RemW'(sdiv));
  assign cprod = RemW'(cq0[RemW-1:0] * RemW'(cdiv));
  assign srem  = snl_r[2] - sprod;
  assign crem  = cnl_r[2] - cprod;
  assign sfix  = srem >= RemW'(sdiv);
  assign cfix  = crem >= RemW'(cdiv);

  always_comb begin
    out_nxt       = sb_r[SbDepth-1];
    out_nxt.sterm = sq0 + QW'(sfix);
    out_nxt.cterm = cq0 + QW'(cfix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SbDepth; i++) sb_r[i].valid <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (en) begin
      sb_r[0] <= sb0_nxt;
      for (int i = 1; i < SbDepth; i++) sb_r[i] <= sb_r[i-1];
      snl_r[0] <= sn[RemW-1:0];
      cnl_r[0] <= cn[RemW-1:0];
      for (int i = 1; i < 3; i++) begin
        snl_r[i] <= snl_r[i-1];
        cnl_r[i] <= cnl_r[i-1];
      end
      out_r <= out_nxt;
    end
  end

  assign ser_o = out_r;

endmodule

/* rtl/arm_finish.sv */
// Last term, rounding to Q1.14, quadrant signs and matrix assembly.
// Depends on arm_pkg.
module arm_finish
  import arm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  arm_ser_t ser_i,
  output logic     res_valid,
  output arm_out_t res_data
);

  localparam logic LastNeg = 1'(Terms % 2);
  localparam int RndSh = FracW - OutFrac;
  localparam logic [QW-1:0] Half = QW'(1) << (RndSh - 1);

  logic                   p1_v_r, p2_v_r, p3_v_r;
  arm_meta_t              p1_meta_r;
  logic [QW-1:0]          p1_ssum_r, p1_csum_r;
  logic [1:0]             p2_quad_r;
  logic [OpW-1:0]         p2_op_r;
  logic signed [MatW-1:0] p2_s_r, p2_c_r, p2_ns_r, p2_nc_r;
  arm_out_t               p3_r;

  logic [QW-1:0]          srnd, crnd;
  logic signed [MatW-1:0] smag, cmag, s_nxt, c_nxt;
  logic signed [MatW-1:0] sn, cs, nsn;
  arm_out_t               mat_nxt;

  assign srnd  = p1_ssum_r + Half;
  assign crnd  = p1_csum_r + Half;
  assign smag  = srnd[RndSh+MatW-1:RndSh];
  assign cmag  = crnd[RndSh+MatW-1:RndSh];
  assign s_nxt = p1_meta_r.swap ? cmag : smag;
  assign c_nxt = p1_meta_r.swap ? smag : cmag;

  always_comb begin
    case (p2_quad_r)
      2'd0: begin
        sn = p2_s_r;  cs = p2_c_r;  nsn = p2_ns_r;
      end
      2'd1: begin
        sn = p2_c_r;  cs = p2_ns_r; nsn = p2_nc_r;
      end
      2'd2: begin
        sn = p2_ns_r; cs = p2_nc_r; nsn = p2_s_r;
      end
      default: begin
        sn = p2_nc_r; cs = p2_s_r;  nsn = p2_c_r;
      end
    endcase
  end

  always_comb begin
    mat_nxt     = '0;
    mat_nxt.m00 = OneQ14;
    mat_nxt.m11 = OneQ14;
    mat_nxt.m22 = OneQ14;
    case (p2_op_r)
      OpAxisX: begin
        mat_nxt.m11 = cs;
        mat_nxt.m12 = nsn;
        mat_nxt.m21 = sn;
        mat_nxt.m22 = cs;
      end
      OpAxisY: begin
        mat_nxt.m00 = cs;
        mat_nxt.m02 = sn;
        mat_nxt.m20 = nsn;
        mat_nxt.m22 = cs;
      end
      OpAxisZ: begin
        mat_nxt.m00 = cs;
        mat_nxt.m01 = nsn;
        mat_nxt.m10 = sn;
        mat_nxt.m11 = cs;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r    <= ser_i.valid;
      p1_meta_r <= ser_i.meta;
      p1_ssum_r <= LastNeg ? ser_i.ssum - ser_i.sterm : ser_i.ssum + ser_i.sterm;
      p1_csum_r <= LastNeg ? ser_i.csum - ser_i.cterm : ser_i.csum + ser_i.cterm;
      p2_v_r    <= p1_v_r;
      p2_quad_r <= p1_meta_r.quad;
      p2_op_r   <= p1_meta_r.opcode;
      p2_s_r    <= s_nxt;
      p2_c_r    <= c_nxt;
      p2_ns_r   <= -s_nxt;
      p2_nc_r   <= -c_nxt;
      p3_v_r    <= p2_v_r;
      p3_r      <= mat_nxt;
    end
  end

  assign res_valid = p3_v_r;
  assign res_data  = p3_r;

endmodule

/* rtl/axis_rotation_matrix_gen.sv */
// Elementary 3-D rotation matrix generator (about x, y or z; code 3 gives identity).
// Throughput: one word per cycle while the output is not stalled; the Taylor series runs as 10 seven-stage term units.
// A one-word skid register behind the output register stalls the pipeline by a registered ready.
// Reset: synchronous, active low; clears all valid bits, no other state.
module axis_rotation_matrix_gen
  import arm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  arm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output arm_out_t out_data
);

  logic     en;
  arm_ser_t ser_w [Terms+1];
  logic     res_valid;
  arm_out_t res_data;
  logic     out_valid_r, skid_valid_r;
  arm_out_t out_data_r, skid_data_r;
  logic     out_free;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  arm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ser_o    (ser_w[0])
  );

  for (genvar k = 1; k <= Terms; k++) begin : g_term
    localparam int SDivI = (2 * k) * (2 * k + 1);
    localparam int CDivI = (2 * k - 1) * (2 * k);
    localparam logic [QW:0] SDivW = (QW+1)'(SDivI);
    localparam logic [QW:0] CDivW = (QW+1)'(CDivI);
    localparam logic [QW-1:0] SRecip = QW'(RecipNum / SDivW);
    localparam logic [QW-1:0] CRecip = QW'(RecipNum / CDivW);
    localparam logic Neg = 1'((k - 1) % 2);

    arm_term u_term (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .sdiv   (DivW'(SDivI)),
      .cdiv   (DivW'(CDivI)),
      .srecip (SRecip),
      .crecip (CRecip),
      .neg    (Neg),
      .ser_i  (ser_w[k-1]),
      .ser_o  (ser_w[k])
    );
  end

  arm_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ser_i     (ser_w[Terms]),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      // pipeline moves this cycle, so its last word must land somewhere
      if (out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_data;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res_data;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for axis_rotation_matrix_gen: directed and random angle/axis words,
// a bit-exact fixed-point rotation matrix predictor, random idling on both channels.
// Depends on arm_pkg and the axis_rotation_matrix_gen RTL.
module testbench;
  import arm_pkg::*;

  localparam logic [OpW-1:0] OpIdentity = 2'd3;
  localparam int Turn    = 46080;          // 360 degrees in 1/128 degree units
  localparam int Quarter = Turn / 4;
  localparam int Eighth  = Turn / 8;
  localparam logic [63:0] PiFix  = 64'hC90FDAA22168C234;
  localparam logic [63:0] OneFix = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HalfLsb = 64'h0000_8000_0000_0000;
  localparam int NumRandom = 450;
  localparam int DrainCycles = 120;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  arm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  arm_out_t out_data;

  arm_in_t  pending_words[$];
  arm_out_t expected_matrices[$];
  int       mismatch_count = 0;
  int       send_gap = 0;
  int       recv_stall = 0;
  int       stall_draw;
  bit       send_burst = 1'b0;
  bit       recv_burst = 1'b0;

  axis_rotation_matrix_gen i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // (a * b) >> 62 on the full 128-bit product
  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  function automatic int fix_to_q14(logic [63:0] v);
    logic [63:0] r;
    r = (v + HalfLsb) >> 48;
    return int'(r);
  endfunction

  // Taylor sine/cosine magnitudes for t in [0, 45 degrees]
  function automatic void octant_sin_cos(input int t, output int s, output int c);
    logic [63:0] rad_step, x, x2, ssum, csum, sterm, cterm;
    rad_step = PiFix / 64'd23040;
    x = 64'(t) * rad_step;
    x2 = fix_mul(x, x);
    ssum = x;
    csum = OneFix;
    sterm = x;
    cterm = OneFix;
    for (int k = 1; k <= 10; k++) begin
      sterm = fix_mul(sterm, x2) / 64'((2 * k) * (2 * k + 1));
      cterm = fix_mul(cterm, x2) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ssum = ssum - sterm;
        csum = csum - cterm;
      end else begin
        ssum = ssum + sterm;
        csum = csum + cterm;
      end
    end
    s = fix_to_q14(ssum);
    c = fix_to_q14(csum);
  endfunction

  function automatic arm_out_t rotation_matrix(arm_in_t w);
    int ang, red, quad, rem, s0, c0, sn, cs;
    arm_out_t m;
    ang = $signed(w.angle_deg);
    red = ang % Turn;
    if (red < 0) red = red + Turn;
    quad = red / Quarter;
    rem = red % Quarter;
    // past 45 degrees fold onto the complement and swap sine and cosine
    if (rem <= Eighth) octant_sin_cos(rem, s0, c0);
    else octant_sin_cos(Quarter - rem, c0, s0);
    case (quad)
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
    m = '0;
    m.m00 = OneQ14;
    m.m11 = OneQ14;
    m.m22 = OneQ14;
    case (w.opcode)
      OpAxisX: begin
        m.m11 = 16'(cs); m.m12 = 16'(-sn);
        m.m21 = 16'(sn); m.m22 = 16'(cs);
      end
      OpAxisY: begin
        m.m00 = 16'(cs);  m.m02 = 16'(sn);
        m.m20 = 16'(-sn); m.m22 = 16'(cs);
      end
      OpAxisZ: begin
        m.m00 = 16'(cs); m.m01 = 16'(-sn);
        m.m10 = 16'(sn); m.m11 = 16'(cs);
      end
      default: ;
    endcase
    return m;
  endfunction

  // per-word idle draw; bursts with no idling come and go at random
  function automatic int draw_idle(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic compare_entry(string name, logic signed [MatW-1:0] exp_v,
                               logic signed [MatW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic check_matrix(arm_out_t got);
    arm_out_t exp_m;
    if (expected_matrices.size() == 0) begin
      $error("result word with no expectation pending");
      mismatch_count++;
    end else begin
      exp_m = expected_matrices.pop_front();
      compare_entry("m00", exp_m.m00, got.m00);
      compare_entry("m01", exp_m.m01, got.m01);
      compare_entry("m02", exp_m.m02, got.m02);
      compare_entry("m10", exp_m.m10, got.m10);
      compare_entry("m11", exp_m.m11, got.m11);
      compare_entry("m12", exp_m.m12, got.m12);
      compare_entry("m20", exp_m.m20, got.m20);
      compare_entry("m21", exp_m.m21, got.m21);
      compare_entry("m22", exp_m.m22, got.m22);
    end
  endtask

  task automatic queue_word(int angle, logic [OpW-1:0] op);
    arm_in_t w;
    w.angle_deg = AngW'(angle);
    w.opcode = op;
    pending_words.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_matrices.push_back(rotation_matrix(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= draw_idle(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (out_valid && out_ready) begin
      check_matrix(out_data);
      stall_draw = draw_idle(recv_burst);
      recv_stall <= stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      out_ready <= (recv_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int sel, ang;
    // field extremes, every axis, quadrant and octant edges, identity with odd angles
    queue_word(0, OpAxisX);
    queue_word(-8388608, OpAxisX);
    queue_word(8388607, OpAxisY);
    queue_word(-8388608, OpAxisZ);
    queue_word(8388607, OpIdentity);
    queue_word(-8388608, OpIdentity);
    queue_word(1, OpAxisZ);
    queue_word(-1, OpAxisZ);
    queue_word(Eighth - 1, OpAxisX);
    queue_word(Eighth, OpAxisY);
    queue_word(Eighth + 1, OpAxisZ);
    queue_word(Quarter, OpAxisX);
    queue_word(Quarter + Eighth, OpAxisY);
    queue_word(2 * Quarter, OpAxisZ);
    queue_word(3 * Quarter, OpAxisX);
    queue_word(3 * Quarter + 1, OpAxisY);
    queue_word(Turn - 1, OpAxisZ);
    queue_word(Turn, OpAxisX);
    queue_word(-Turn, OpAxisY);
    queue_word(-Eighth, OpAxisZ);
    queue_word(-Quarter - 7, OpAxisX);
    queue_word(12345, OpIdentity);
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) ang = $signed(AngW'($urandom_range(0, 24'hFFFFFF)));
      else if (sel < 7) ang = ($urandom_range(0, 32) - 16) * Eighth + $urandom_range(0, 6) - 3;
      else ang = $urandom_range(0, 4 * Turn - 1) - 2 * Turn;
      queue_word(ang, OpW'($urandom_range(0, 3)));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_matrices.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/arm_pkg.sv
rtl/arm_mul.sv
rtl/arm_front.sv
rtl/arm_term.sv
rtl/arm_finish.sv
rtl/axis_rotation_matrix_gen.sv
test/testbench.sv
